// ===== rtl/plr_pkg.sv =====
// plr_pkg: shared widths, request codes and structs for the planar line rasteriser.
// Used by plr_line_core and planar_line_rasterizer; no dependencies of its own.
package plr_pkg;

	localparam int COORD_BITS  = 10;
	localparam int DEC_BITS    = COORD_BITS + 3;
	localparam int AXIAL_BITS  = COORD_BITS + 2;
	localparam int ROW_BITS    = 10;
	localparam int ADDR_BITS   = 16;
	localparam int COLOR_BITS  = 8;
	localparam int OP_BITS     = 8;
	localparam int PLANES      = 4;
	localparam int PLANE_BITS  = 2;
	localparam int PROD_BITS   = COORD_BITS + ROW_BITS;

	localparam logic [ROW_BITS-1:0] ROW_BYTES_RESET = ROW_BITS'(90);

	localparam int IN_RAW_BITS   = 4 * COORD_BITS + COLOR_BITS + OP_BITS;
	localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
	localparam int OUT_RAW_BITS  = 2 * COORD_BITS + ADDR_BITS + PLANES + COLOR_BITS + OP_BITS;
	localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_STEP = 1'b1
	} cmd_t;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		cmd_t                  cmd;
		coord_t                start_x;
		coord_t                start_y;
		coord_t                end_x;
		coord_t                end_y;
		logic [COLOR_BITS-1:0] pen_color;
		logic [OP_BITS-1:0]    raster_op;
	} line_req_t;

	typedef struct packed {
		coord_t                x;
		coord_t                y;
		logic [COLOR_BITS-1:0] color;
		logic [OP_BITS-1:0]    op;
		logic                  last;
	} pix_t;

endpackage

// ===== rtl/planar_line_rasterizer.sv =====
// planar_line_rasterizer: top level, stream ports, request and result pipeline, addressing.
// Depends on plr_pkg and plr_line_core.
//
//  channel   direction  handshake                       payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   tuser = cmd, tdata = endpoints, colour, op
//  m_axis    out        m_axis_tvalid / m_axis_tready   tdata = pixel, address, mask; tlast
//  cfg       in         cfg_we (no ready)               cfg_wdata = bytes_per_row
//
// One request per clock while s_axis_tready is high. The line state and the next pixel are
// settled at acceptance (stage 1), the row multiply and byte address at stage 2, which is
// the output register.
// Reset clears the line state, the valid flags and bytes_per_row (to 90).
// A stalled output holds stage 2; stage 1 still takes a request while stage 2 is free or
// being drained, so s_axis_tready only drops when both stages hold pixels.
module planar_line_rasterizer (
	input  logic                               clk,
	input  logic                               arst_n,
	// bytes_per_row write
	input  logic                               cfg_we,
	input  logic [plr_pkg::ROW_BITS-1:0]       cfg_wdata,
	// requests
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// start_x, start_y, end_x, end_y, pen_color, raster_op (lowest first)
	input  logic [plr_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
	// cmd: 0 load, 1 step
	input  logic                               s_axis_tuser,
	// pixels
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// pix_x, pix_y, byte_address, plane_mask, out_color, out_op (lowest first)
	output logic [plr_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
	// last_pixel
	output logic                               m_axis_tlast
);
	import plr_pkg::*;

	localparam int CW = COORD_BITS;

	logic [ROW_BITS-1:0]  row_bytes_q;

	line_req_t            req;
	pix_t                 pix_nxt;
	logic                 emit;
	logic                 take;
	logic                 adv1;

	logic                 valid_s1;
	pix_t                 pix_s1;

	logic                 valid_s2;
	logic [OUT_RAW_BITS-1:0] data_s2;
	logic                 last_s2;

	logic [PROD_BITS-1:0] row_prod;
	logic [ADDR_BITS-1:0] byte_addr;
	logic [PLANES-1:0]    mask;

	// unpack the request
	assign req.cmd       = cmd_t'(s_axis_tuser);
	assign req.start_x   = s_axis_tdata[CW-1:0];
	assign req.start_y   = s_axis_tdata[2*CW-1:CW];
	assign req.end_x     = s_axis_tdata[3*CW-1:2*CW];
	assign req.end_y     = s_axis_tdata[4*CW-1:3*CW];
	assign req.pen_color = s_axis_tdata[4*CW+COLOR_BITS-1:4*CW];
	assign req.raster_op = s_axis_tdata[4*CW+COLOR_BITS+OP_BITS-1:4*CW+COLOR_BITS];

	// stage 2 moves on when empty or drained; stage 1 when stage 2 will take it
	assign adv1          = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv1;
	assign take          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			row_bytes_q <= ROW_BYTES_RESET;
		else if (cfg_we)
			row_bytes_q <= cfg_wdata;
	end

	plr_line_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.req    (req),
		.pix    (pix_nxt),
		.emit   (emit)
	);

	// stage 1: pixel as settled at acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take)
			valid_s1 <= emit;
		else if (adv1)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take)
			pix_s1 <= pix_nxt;
	end

	// planar addressing: y * bytes_per_row + x / 4, mask from x mod 4
	assign row_prod  = pix_s1.y * row_bytes_q;
	assign byte_addr = row_prod[ADDR_BITS-1:0] + ADDR_BITS'(pix_s1.x >> PLANE_BITS);
	assign mask      = PLANES'(1) << pix_s1.x[PLANE_BITS-1:0];

	// stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv1)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv1 && valid_s1) begin
			data_s2 <= {pix_s1.op, pix_s1.color, mask, byte_addr, pix_s1.y, pix_s1.x};
			last_s2 <= pix_s1.last;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = OUT_DATA_BITS'(data_s2);
	assign m_axis_tlast  = last_s2;

	a_mask_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot(m_axis_tdata[2*CW+ADDR_BITS+PLANES-1:2*CW+ADDR_BITS]))
		else $error("plane mask not one-hot");

	a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv1) |=> valid_s1)
		else $error("stage 1 pixel lost under stall");

	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_axis_tready) |-> !take)
		else $error("request taken with both stages full");

endmodule

// ===== rtl/plr_line_core.sv =====
// plr_line_core: Bresenham line state and next-pixel logic, one request per clock while take is high.
// Depends on plr_pkg.
module plr_line_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  plr_pkg::line_req_t req,
	output plr_pkg::pix_t     pix,
	output logic              emit
);
	import plr_pkg::*;

	logic                        active_q;
	coord_t                      cur_x_q, cur_y_q, major_end_q;
	logic                        y_major_q, minor_neg_q;
	logic signed [DEC_BITS-1:0]  decision_q, diag_q;
	logic [AXIAL_BITS-1:0]       axial_q;
	logic [COLOR_BITS-1:0]       color_q;
	logic [OP_BITS-1:0]          op_q;

	// load set-up
	coord_t                      adx, ady, sx0, sy0, sx1, sy1, dmaj, dmin, ld_end;
	logic                        ld_ymaj, ld_swap, ld_neg, ld_last;
	logic signed [DEC_BITS-1:0]  ld_dec, ld_diag;
	logic [AXIAL_BITS-1:0]       ld_axial;

	// step
	coord_t                      maj_cur, min_cur, maj_nxt, min_nxt, st_x, st_y;
	logic                        diag_move, st_last;
	logic signed [DEC_BITS-1:0]  st_dec;

	always_comb begin
		adx     = (req.end_x > req.start_x) ? req.end_x - req.start_x : req.start_x - req.end_x;
		ady     = (req.end_y > req.start_y) ? req.end_y - req.start_y : req.start_y - req.end_y;
		ld_ymaj = adx < ady;
		ld_swap = ld_ymaj ? (req.start_y > req.end_y) : (req.start_x > req.end_x);
		sx0     = ld_swap ? req.end_x : req.start_x;
		sy0     = ld_swap ? req.end_y : req.start_y;
		sx1     = ld_swap ? req.start_x : req.end_x;
		sy1     = ld_swap ? req.start_y : req.end_y;
		ld_neg  = ld_ymaj ? !(sx1 > sx0) : !(sy1 > sy0);
		dmaj    = ld_ymaj ? ady : adx;
		dmin    = ld_ymaj ? adx : ady;
		ld_end  = ld_ymaj ? sy1 : sx1;
		ld_last = (ld_ymaj ? sy0 : sx0) == ld_end;
		ld_dec  = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
		ld_diag = $signed({2'b00, dmin, 1'b0}) - $signed({2'b00, dmaj, 1'b0});
		ld_axial = {1'b0, dmin, 1'b0};
	end

	always_comb begin
		maj_cur   = y_major_q ? cur_y_q : cur_x_q;
		min_cur   = y_major_q ? cur_x_q : cur_y_q;
		diag_move = !decision_q[DEC_BITS-1];
		maj_nxt   = maj_cur + COORD_BITS'(1);
		if (!diag_move)
			min_nxt = min_cur;
		else if (minor_neg_q)
			min_nxt = min_cur - COORD_BITS'(1);
		else
			min_nxt = min_cur + COORD_BITS'(1);
		st_dec  = diag_move ? decision_q + diag_q : decision_q + $signed({1'b0, axial_q});
		st_x    = y_major_q ? min_nxt : maj_nxt;
		st_y    = y_major_q ? maj_nxt : min_nxt;
		st_last = maj_nxt == major_end_q;
	end

	always_comb begin
		if (req.cmd == CMD_LOAD) begin
			emit = 1'b1;
			pix  = '{x: sx0, y: sy0, color: req.pen_color, op: req.raster_op, last: ld_last};
		end else begin
			emit = active_q;
			pix  = '{x: st_x, y: st_y, color: color_q, op: op_q, last: st_last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			major_end_q <= '0;
			y_major_q   <= 1'b0;
			minor_neg_q <= 1'b0;
			decision_q  <= '0;
			diag_q      <= '0;
			axial_q     <= '0;
			color_q     <= '0;
			op_q        <= '0;
		end else if (take) begin
			if (req.cmd == CMD_LOAD) begin
				active_q    <= !ld_last;
				cur_x_q     <= sx0;
				cur_y_q     <= sy0;
				major_end_q <= ld_end;
				y_major_q   <= ld_ymaj;
				minor_neg_q <= ld_neg;
				decision_q  <= ld_dec;
				diag_q      <= ld_diag;
				axial_q     <= ld_axial;
				color_q     <= req.pen_color;
				op_q        <= req.raster_op;
			end else if (active_q) begin
				cur_x_q    <= st_x;
				cur_y_q    <= st_y;
				decision_q <= st_dec;
				if (st_last)
					active_q <= 1'b0;
			end
		end
	end

	// a running line never sits on its end point
	a_active_not_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> ((y_major_q ? cur_y_q : cur_x_q) != major_end_q))
		else $error("line active at its end point");

	a_idle_step_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(req.cmd == CMD_STEP && !active_q) |-> !emit)
		else $error("pixel emitted by a step while idle");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(take && emit && pix.last) |=> !active_q)
		else $error("line still active after its last pixel");

endmodule

// ===== test/plr_pixel_checker.sv =====
// plr_pixel_checker: watches the request, pixel and bytes_per_row channels of the rasteriser,
// works out every pixel from its own copy of the line state and compares field by field.
// Depends on plr_pkg only.
module plr_pixel_checker
	import plr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [ROW_BITS-1:0]      cfg_wdata,
	input  logic                     s_axis_tvalid,
	input  logic                     s_axis_tready,
	input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
	input  logic                     s_axis_tuser,
	input  logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	input  logic [OUT_DATA_BITS-1:0] m_axis_tdata,
	input  logic                     m_axis_tlast,
	output int                       mismatch_count,
	output int                       pixels_owed
);

	// request tdata: start_x, start_y, end_x, end_y, pen_color, raster_op
	localparam int IN_COLOR_LSB = 4 * COORD_BITS;
	localparam int IN_OP_LSB    = IN_COLOR_LSB + COLOR_BITS;
	// pixel tdata: pix_x, pix_y, byte_address, plane_mask, out_color, out_op
	localparam int ADDR_LSB      = 2 * COORD_BITS;
	localparam int MASK_LSB      = ADDR_LSB + ADDR_BITS;
	localparam int OUT_COLOR_LSB = MASK_LSB + PLANES;
	localparam int OUT_OP_LSB    = OUT_COLOR_LSB + COLOR_BITS;

	typedef struct packed {
		coord_t                x;
		coord_t                y;
		logic [ADDR_BITS-1:0]  addr;
		logic [PLANES-1:0]     mask;
		logic [COLOR_BITS-1:0] color;
		logic [OP_BITS-1:0]    op;
		logic                  last;
	} pixel_word_t;

	pixel_word_t awaited_pixels[$];
	int          mismatches = 0;

	// shadow of the line walker
	logic [ROW_BITS-1:0]          row_bytes;
	logic                         drawing, steep, minor_down;
	coord_t                       pen_x, pen_y, major_stop;
	logic signed [DEC_BITS-1:0]   err_term, diag_step;
	logic [AXIAL_BITS-1:0]        axial_step;
	logic [COLOR_BITS-1:0]        pen_color;
	logic [OP_BITS-1:0]           pen_op;

	function automatic void compare_field(string field, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endfunction

	task automatic advance_pen(input line_req_t req, output logic emitted,
			output pixel_word_t px);
		int   x0, y0, x1, y1, adx, ady, dmaj, dmin;
		logic at_end;
		emitted = 1'b0;
		px = '0;
		if (req.cmd == CMD_LOAD) begin
			x0 = int'(req.start_x);
			y0 = int'(req.start_y);
			x1 = int'(req.end_x);
			y1 = int'(req.end_y);
			adx = (x1 > x0) ? x1 - x0 : x0 - x1;
			ady = (y1 > y0) ? y1 - y0 : y0 - y1;
			pen_color = req.pen_color;
			pen_op = req.raster_op;
			// ties go to x
			steep = adx < ady;
			// always walk with the major coordinate rising
			if (steep ? (y0 > y1) : (x0 > x1)) begin
				{x0, x1} = {x1, x0};
				{y0, y1} = {y1, y0};
			end
			minor_down = steep ? !(x1 > x0) : !(y1 > y0);
			dmaj = steep ? ady : adx;
			dmin = steep ? adx : ady;
			major_stop = coord_t'(steep ? y1 : x1);
			err_term = DEC_BITS'(2 * dmin - dmaj);
			diag_step = DEC_BITS'(2 * (dmin - dmaj));
			axial_step = AXIAL_BITS'(2 * dmin);
			pen_x = coord_t'(x0);
			pen_y = coord_t'(y0);
		end else if (drawing) begin
			if (steep)
				pen_y = pen_y + 1'b1;
			else
				pen_x = pen_x + 1'b1;
			if (err_term >= 0) begin
				if (steep)
					pen_x = minor_down ? pen_x - 1'b1 : pen_x + 1'b1;
				else
					pen_y = minor_down ? pen_y - 1'b1 : pen_y + 1'b1;
				err_term = err_term + diag_step;
			end else begin
				err_term = err_term + $signed({1'b0, axial_step});
			end
		end else begin
			// step with no line open: nothing comes out
			return;
		end
		at_end = (steep ? pen_y : pen_x) == major_stop;
		drawing = !at_end;
		emitted = 1'b1;
		px.x = pen_x;
		px.y = pen_y;
		px.addr = ADDR_BITS'(int'(pen_y) * int'(row_bytes) + int'(pen_x >> 2));
		px.mask = PLANES'(1) << pen_x[PLANE_BITS-1:0];
		px.color = pen_color;
		px.op = pen_op;
		px.last = at_end;
	endtask

	always @(posedge clk or negedge arst_n) begin
		line_req_t   req;
		logic        emitted;
		pixel_word_t want;
		if (!arst_n) begin
			row_bytes = ROW_BYTES_RESET;
			drawing = 1'b0;
			steep = 1'b0;
			minor_down = 1'b0;
			pen_x = '0;
			pen_y = '0;
			major_stop = '0;
			err_term = '0;
			diag_step = '0;
			axial_step = '0;
			pen_color = '0;
			pen_op = '0;
			awaited_pixels.delete();
		end else begin
			if (cfg_we)
				row_bytes = cfg_wdata;
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_pixels.size() == 0) begin
					$error("pixel x %0d y %0d with none awaited",
						m_axis_tdata[0 +: COORD_BITS], m_axis_tdata[COORD_BITS +: COORD_BITS]);
					mismatches++;
				end else begin
					want = awaited_pixels.pop_front();
					compare_field("pix_x", want.x, m_axis_tdata[0 +: COORD_BITS]);
					compare_field("pix_y", want.y, m_axis_tdata[COORD_BITS +: COORD_BITS]);
					compare_field("byte_address", want.addr, m_axis_tdata[ADDR_LSB +: ADDR_BITS]);
					compare_field("plane_mask", want.mask, m_axis_tdata[MASK_LSB +: PLANES]);
					compare_field("out_color", want.color,
						m_axis_tdata[OUT_COLOR_LSB +: COLOR_BITS]);
					compare_field("out_op", want.op, m_axis_tdata[OUT_OP_LSB +: OP_BITS]);
					compare_field("last_pixel", want.last, m_axis_tlast);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				req.cmd = cmd_t'(s_axis_tuser);
				req.start_x = s_axis_tdata[0 +: COORD_BITS];
				req.start_y = s_axis_tdata[COORD_BITS +: COORD_BITS];
				req.end_x = s_axis_tdata[2 * COORD_BITS +: COORD_BITS];
				req.end_y = s_axis_tdata[3 * COORD_BITS +: COORD_BITS];
				req.pen_color = s_axis_tdata[IN_COLOR_LSB +: COLOR_BITS];
				req.raster_op = s_axis_tdata[IN_OP_LSB +: OP_BITS];
				advance_pen(req, emitted, want);
				if (emitted)
					awaited_pixels.push_back(want);
			end
		end
		mismatch_count <= mismatches;
		pixels_owed <= awaited_pixels.size();
	end

endmodule

// ===== test/planar_line_rasterizer_tb.sv =====
// planar_line_rasterizer_tb: drives line requests and bytes_per_row writes into the rasteriser,
// with random gaps and back-pressure; plr_pixel_checker does the prediction and comparison.
// Depends on plr_pkg, planar_line_rasterizer and plr_pixel_checker.
module planar_line_rasterizer_tb;
	import plr_pkg::*;

	localparam int PHASE_ITEMS = 108;   // counted requests per random phase
	localparam int SQUEEZE_CYCLES = 64; // length of the long output hold-off
	localparam int SETTLE_CYCLES = 6;   // covers the stage 1 and stage 2 registers, plus spare

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [ROW_BITS-1:0]      cfg_wdata = '0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
	logic                     s_axis_tuser = 1'b0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_axis_tdata;
	logic                     m_axis_tlast;

	int mismatch_count;
	int pixels_owed;

	// steady: no gaps on either side; squeeze_req: ask the receiver for one long hold-off
	bit steady = 1'b0;
	bit squeeze_req = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	planar_line_rasterizer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	plr_pixel_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tlast   (m_axis_tlast),
		.mismatch_count (mismatch_count),
		.pixels_owed    (pixels_owed)
	);

	// Hard stop, far beyond the slowest legal run.
	initial begin
		#4_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Pixel sink. Mostly ready, about one cycle in ten held off. When asked, it holds
	// off for a long stretch counted here while the sender keeps pushing requests, so
	// both pipeline stages fill and s_axis_tready has to drop.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				stall_left = SQUEEZE_CYCLES;
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= steady || ($urandom_range(0, 99) >= 10);
			end
		end
	end

	// Length of the line along its major axis, i.e. the number of steps it takes.
	function automatic int major_run(input int x0, y0, x1, y1);
		int adx, ady;
		adx = (x1 > x0) ? x1 - x0 : x0 - x1;
		ady = (y1 > y0) ? y1 - y0 : y0 - y1;
		return (adx > ady) ? adx : ady;
	endfunction

	// A coordinate within span of c, kept on screen.
	function automatic int nudge(input int c, input int span);
		int v;
		v = c + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return v;
	endfunction

	// Step request; its payload is ignored by the block, so fill it with noise.
	function automatic line_req_t random_step();
		line_req_t r;
		r.cmd = CMD_STEP;
		r.start_x = coord_t'($urandom);
		r.start_y = coord_t'($urandom);
		r.end_x = coord_t'($urandom);
		r.end_y = coord_t'($urandom);
		r.pen_color = COLOR_BITS'($urandom);
		r.raster_op = OP_BITS'($urandom);
		return r;
	endfunction

	// Present one request and hold it until it is taken. Returns in the time step of the
	// accepting edge, so the next request (or a gap) is set up by a single assignment.
	// Outside steady mode, a gap of random length before about 4% of requests keeps the idle share near 10%.
	task automatic offer_request(input line_req_t r);
		if (!steady && $urandom_range(0, 99) < 4) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= r.cmd;
		s_axis_tdata <= IN_DATA_BITS'({r.raster_op, r.pen_color,
			r.end_y, r.end_x, r.start_y, r.start_x});
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Load a line, then issue the given number of steps. Steps past the end point are
	// ignored by the block and are not counted; fewer steps leave the line open so the
	// next load abandons it.
	task automatic draw_line(input int x0, y0, x1, y1, input logic [COLOR_BITS-1:0] colour,
			input logic [OP_BITS-1:0] op, input int steps, output int counted);
		line_req_t r;
		int run;
		run = major_run(x0, y0, x1, y1);
		r.cmd = CMD_LOAD;
		r.start_x = coord_t'(x0);
		r.start_y = coord_t'(y0);
		r.end_x = coord_t'(x1);
		r.end_y = coord_t'(y1);
		r.pen_color = colour;
		r.raster_op = op;
		offer_request(r);
		for (int i = 0; i < steps; i++)
			offer_request(random_step());
		counted = 1 + ((steps < run) ? steps : run);
	endtask

	// Stop requests and wait until every predicted pixel is out. The owed count is
	// registered in the checker, so it is read late; the spare cycles cover
	// steps on an idle block still in the pipe, which owe nothing.
	task automatic drain_pixels();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pixels_owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_row_bytes(input logic [ROW_BITS-1:0] value);
		drain_pixels();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int                  taken, items, pick, span, run, steps;
		int                  x0, y0, x1, y1;
		logic [ROW_BITS-1:0] row;
		bit                  line_open;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, bytes_per_row at its reset value.
		// single point at the far corner, then a step with nothing open
		draw_line(1023, 1023, 1023, 1023, 8'hFF, 8'h00, 1, taken);
		// x major given right to left: endpoints swapped, y falling
		draw_line(3, 7, 0, 9, 8'h00, 8'hFF, 3, taken);
		// y major with x falling, one step too many
		draw_line(2, 1, 0, 4, 8'h5A, 8'hA5, 4, taken);
		// exact diagonal: tie goes to x
		draw_line(0, 1023, 3, 1020, 8'hC3, 8'h3C, 3, taken);
		// full-width line abandoned by the next load
		draw_line(0, 0, 1023, 0, 8'h01, 8'h80, 2, taken);
		// vertical line
		draw_line(10, 10, 10, 12, 8'h80, 8'h01, 2, taken);
		// full-screen anti-diagonal, left open across the register write
		draw_line(1023, 0, 0, 1023, 8'hE7, 8'h18, 2, taken);
		line_open = 1'b1;

		// Random phases, one bytes_per_row setting each: largest, one, zero (address
		// becomes x / 4), two random values, then back to the reset value.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: row = '1;
				1: row = ROW_BITS'(1);
				2: row = '0;
				5: row = ROW_BYTES_RESET;
				default: row = ROW_BITS'($urandom_range(2, 1022));
			endcase
			set_row_bytes(row);
			steady = (phase == 2);
			if (phase == 0 || phase == 4)
				squeeze_req = 1'b1;
			items = 0;
			while (items < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 8 && !line_open) begin
					// stray step on an idle block
					offer_request(random_step());
				end else if (pick < 20) begin
					// anywhere to anywhere, usually broken off early
					x0 = $urandom_range(0, 1023);
					y0 = $urandom_range(0, 1023);
					x1 = $urandom_range(0, 1023);
					y1 = $urandom_range(0, 1023);
					run = major_run(x0, y0, x1, y1);
					steps = $urandom_range(0, 24);
					draw_line(x0, y0, x1, y1, COLOR_BITS'($urandom), OP_BITS'($urandom),
						steps, taken);
					items += taken;
					line_open = steps < run;
				end else begin
					// short line, mostly drawn to its end point
					span = $urandom_range(0, 12);
					x0 = $urandom_range(0, 1023);
					y0 = $urandom_range(0, 1023);
					x1 = nudge(x0, span);
					y1 = nudge(y0, span);
					run = major_run(x0, y0, x1, y1);
					if ($urandom_range(0, 99) < 70)
						steps = run + int'($urandom_range(0, 1));
					else
						steps = $urandom_range(0, run);
					draw_line(x0, y0, x1, y1, COLOR_BITS'($urandom), OP_BITS'($urandom),
						steps, taken);
					items += taken;
					line_open = steps < run;
				end
			end
		end
		steady = 1'b0;

		drain_pixels();
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
